// File: rtl/core/mpe_pkg.sv
`default_nettype none

package mpe_pkg;

    // Datagram and section geometry.
    localparam int MAX_DATAGRAM = 4082;
    localparam int PREFIX_LEN   = 20;
    localparam int HDR_LEN      = 12;
    localparam int CRC_LEN      = 4;
    localparam int SECTION_MOD  = 184;
    localparam int SLEN_EXTRA   = 13;

    localparam int LEN_W    = 12;
    localparam int CNT_W    = 5;
    localparam int MOD_W    = 8;
    localparam int MCAST_LO = 16;

    // Header byte values.
    localparam logic [7:0] TABLE_ID    = 8'h3E;
    localparam logic [7:0] SLEN_FLAGS  = 8'hB0;
    localparam logic [7:0] HDR_FLAGS   = 8'hC1;
    localparam logic [7:0] MAC_OUI_MID = 8'h5E;
    localparam logic [7:0] MCAST_MASK  = 8'hE0;
    localparam logic [7:0] MAC_LO_MASK = 8'h7F;

    // MPEG-2 CRC-32.
    localparam logic [31:0] CRC_POLY = 32'h04C11DB7;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // Source of the next output beat.
    typedef enum logic [2:0] {
        SRC_IN,
        SRC_HDR,
        SRC_PRE,
        SRC_CRC,
        SRC_STUFF
    } src_t;

    typedef enum logic [2:0] {
        ST_ACCEPT,
        ST_HDR,
        ST_PRE,
        ST_CRC,
        ST_STUFF
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic load;
        src_t src;
        logic last;
        logic finish;
        logic cnt_clr;
        logic cnt_inc;
    } mpe_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_prefix;
        logic trigger;
        logic ends;
        logic out_free;
        logic hdr_last;
        logic pre_last;
        logic crc_last;
        logic end_held;
        logic stuff_needed;
    } mpe_status_t;

    // One byte step of the CRC, MSB first.
    function automatic logic [31:0] crc_update(logic [31:0] crc_in, logic [7:0] data);
        logic [31:0] c;
        c = crc_in ^ {data, 24'h000000};
        for (int k = 0; k < 8; k++)
        begin
            if (c[31])
            begin
                c = {c[30:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[30:0], 1'b0};
            end
        end
        return c;
    endfunction

    // Section header byte at a given index.
    function automatic logic [7:0] hdr_byte(logic [3:0] idx, logic [LEN_W-1:0] slen,
                                            logic mcast, logic [7:0] m17,
                                            logic [7:0] m18, logic [7:0] m19);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            4'd0:  b = TABLE_ID;
            4'd1:  b = SLEN_FLAGS | {4'h0, slen[11:8]};
            4'd2:  b = slen[7:0];
            4'd3:  b = mcast ? m19 : 8'h00;
            4'd4:  b = mcast ? m18 : 8'h00;
            4'd5:  b = HDR_FLAGS;
            4'd8:  b = mcast ? (m17 & MAC_LO_MASK) : 8'h00;
            4'd9:  b = mcast ? MAC_OUI_MID : 8'h00;
            4'd11: b = {7'h00, mcast};
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/mpe_ctrl.sv
`default_nettype none

module mpe_ctrl
    import mpe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire mpe_status_t st,
    output mpe_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // Input is taken in the accept state; prefix bytes need no output slot.
    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCEPT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ACCEPT:
            begin
                if (accept && st.trigger)
                begin
                    state_next = ST_HDR;
                end
                else if (accept && !st.in_prefix && st.ends)
                begin
                    state_next = ST_CRC;
                end
            end
            ST_HDR:
            begin
                if (st.out_free && st.hdr_last)
                begin
                    state_next = ST_PRE;
                end
            end
            ST_PRE:
            begin
                if (st.out_free && st.pre_last)
                begin
                    state_next = st.end_held ? ST_CRC : ST_ACCEPT;
                end
            end
            ST_CRC:
            begin
                if (st.out_free && st.crc_last)
                begin
                    state_next = st.stuff_needed ? ST_STUFF : ST_ACCEPT;
                end
            end
            ST_STUFF:
            begin
                if (st.out_free)
                begin
                    state_next = ST_ACCEPT;
                end
            end
            default: state_next = ST_ACCEPT;
        endcase
    end

    // Output logic.
    always_comb
    begin
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.src     = SRC_IN;
        unique case (state_reg)
            ST_ACCEPT:
            begin
                in_ready   = st.in_prefix || st.out_free;
                cmd.accept = accept;
                if (accept && !st.in_prefix)
                begin
                    cmd.load    = 1'b1;
                    cmd.src     = SRC_IN;
                    cmd.cnt_clr = st.ends;
                end
                if (accept && st.trigger)
                begin
                    cmd.cnt_clr = 1'b1;
                end
            end
            ST_HDR:
            begin
                if (st.out_free)
                begin
                    cmd.load    = 1'b1;
                    cmd.src     = SRC_HDR;
                    cmd.cnt_clr = st.hdr_last;
                    cmd.cnt_inc = !st.hdr_last;
                end
            end
            ST_PRE:
            begin
                if (st.out_free)
                begin
                    cmd.load    = 1'b1;
                    cmd.src     = SRC_PRE;
                    cmd.cnt_clr = st.pre_last;
                    cmd.cnt_inc = !st.pre_last;
                end
            end
            ST_CRC:
            begin
                if (st.out_free)
                begin
                    cmd.load    = 1'b1;
                    cmd.src     = SRC_CRC;
                    cmd.cnt_inc = !st.crc_last;
                    cmd.last    = st.crc_last && !st.stuff_needed;
                    cmd.finish  = st.crc_last && !st.stuff_needed;
                end
            end
            ST_STUFF:
            begin
                if (st.out_free)
                begin
                    cmd.load   = 1'b1;
                    cmd.src    = SRC_STUFF;
                    cmd.last   = 1'b1;
                    cmd.finish = 1'b1;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/mpe_datapath.sv
`default_nettype none

module mpe_datapath
    import mpe_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write_en,
    input  wire logic             cfg_write_data,
    input  wire logic [7:0]       data_byte,
    input  wire logic [LEN_W-1:0] datagram_length,
    input  wire mpe_cmd_t         cmd,
    output mpe_status_t           st,
    input  wire logic             out_ready,
    output logic                  out_valid,
    output logic [7:0]            out_byte,
    output logic                  is_stuff_run,
    output logic [7:0]            run_length,
    output logic                  last
);

    // Prefix store, written at the byte position, read at the step counter.
    logic [7:0]       store_reg [PREFIX_LEN];

    logic [LEN_W-1:0] pos_reg;
    logic [LEN_W-1:0] pos_next;
    logic [31:0]      crc_reg;
    logic [31:0]      crc_next;
    logic [MOD_W-1:0] mod_reg;
    logic [MOD_W-1:0] mod_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             stuff_en_reg;

    logic [LEN_W-1:0] slen_reg;
    logic             mcast_reg;
    logic [7:0]       mac17_reg;
    logic [7:0]       mac18_reg;
    logic [7:0]       mac19_reg;
    logic [CNT_W-1:0] prefix_last_reg;
    logic             end_held_reg;

    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             is_stuff_run_reg;
    logic [7:0]       run_length_reg;
    logic             last_reg;

    logic [LEN_W-1:0] len_clamped;
    logic [LEN_W-1:0] pos_inc;
    logic [CNT_W-1:0] pos_idx;
    logic             ends;
    logic             in_prefix;
    logic             trigger;
    logic [7:0]       pk [4];
    logic [7:0]       load_byte;

    // Clamp the length and find the end of the datagram.
    always_comb
    begin
        if (datagram_length == '0)
        begin
            len_clamped = LEN_W'(1);
        end
        else if (datagram_length > LEN_W'(MAX_DATAGRAM))
        begin
            len_clamped = LEN_W'(MAX_DATAGRAM);
        end
        else
        begin
            len_clamped = datagram_length;
        end
    end

    assign pos_inc   = pos_reg + LEN_W'(1);
    assign pos_idx   = pos_reg[CNT_W-1:0];
    assign ends      = (pos_inc >= len_clamped) || (pos_inc >= LEN_W'(MAX_DATAGRAM));
    assign in_prefix = pos_reg < LEN_W'(PREFIX_LEN);
    assign trigger   = in_prefix && ((pos_idx == CNT_W'(PREFIX_LEN - 1)) || ends);

    // Bytes 16 to 19 as the header sees them; bytes not yet received read as zero.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (pos_idx < CNT_W'(MCAST_LO + k))
            begin
                pk[k] = 8'h00;
            end
            else if (pos_idx == CNT_W'(MCAST_LO + k))
            begin
                pk[k] = data_byte;
            end
            else
            begin
                pk[k] = store_reg[MCAST_LO + k];
            end
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stuff_en_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            stuff_en_reg <= cfg_write_data;
        end
    end

    // Prefix store writes.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && in_prefix)
        begin
            store_reg[pos_idx] <= data_byte;
        end
    end

    // Header fields latched when the header burst is triggered.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && trigger)
        begin
            slen_reg        <= len_clamped + LEN_W'(SLEN_EXTRA);
            mcast_reg       <= (pk[0] & MCAST_MASK) == MCAST_MASK;
            mac17_reg       <= pk[1];
            mac18_reg       <= pk[2];
            mac19_reg       <= pk[3];
            prefix_last_reg <= pos_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_held_reg <= 1'b0;
        end
        else if (cmd.accept && trigger)
        begin
            end_held_reg <= ends;
        end
    end

    // Byte position.
    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.accept)
        begin
            pos_next = ends ? '0 : pos_inc;
        end
    end

    // Byte position register and step counter for header, prefix and CRC bursts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    // Byte for the next output beat.
    always_comb
    begin
        case (cmd.src)
            SRC_IN:  load_byte = data_byte;
            SRC_HDR: load_byte = hdr_byte(cnt_reg[3:0], slen_reg, mcast_reg,
                                          mac17_reg, mac18_reg, mac19_reg);
            SRC_PRE: load_byte = store_reg[cnt_reg];
            SRC_CRC:
            begin
                case (cnt_reg[1:0])
                    2'd0:    load_byte = crc_reg[31:24];
                    2'd1:    load_byte = crc_reg[23:16];
                    2'd2:    load_byte = crc_reg[15:8];
                    default: load_byte = crc_reg[7:0];
                endcase
            end
            default: load_byte = 8'h00;
        endcase
    end

    // CRC covers header and datagram; the byte count mod 184 sizes the stuffing.
    always_comb
    begin
        crc_next = crc_reg;
        mod_next = mod_reg;
        if (cmd.load && (cmd.src inside {SRC_IN, SRC_HDR, SRC_PRE}))
        begin
            crc_next = crc_update(crc_reg, load_byte);
        end
        if (cmd.load && (cmd.src != SRC_STUFF))
        begin
            mod_next = (mod_reg == MOD_W'(SECTION_MOD - 1)) ? '0 : mod_reg + MOD_W'(1);
        end
        if (cmd.finish)
        begin
            crc_next = CRC_INIT;
            mod_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT;
            mod_reg <= '0;
        end
        else
        begin
            crc_reg <= crc_next;
            mod_reg <= mod_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_byte_reg     <= load_byte;
            is_stuff_run_reg <= cmd.src == SRC_STUFF;
            run_length_reg   <= (cmd.src == SRC_STUFF) ?
                                MOD_W'(SECTION_MOD - 1) - mod_reg : 8'h00;
            last_reg         <= cmd.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign is_stuff_run = is_stuff_run_reg;
    assign run_length   = run_length_reg;
    assign last         = last_reg;

    // Status to the controller.
    always_comb
    begin
        st.in_prefix    = in_prefix;
        st.trigger      = trigger;
        st.ends         = ends;
        st.out_free     = !out_valid_reg || out_ready;
        st.hdr_last     = cnt_reg == CNT_W'(HDR_LEN - 1);
        st.pre_last     = cnt_reg == prefix_last_reg;
        st.crc_last     = cnt_reg == CNT_W'(CRC_LEN - 1);
        st.end_held     = end_held_reg;
        st.stuff_needed = stuff_en_reg && (mod_reg != MOD_W'(SECTION_MOD - 2));
    end

    // A beat is only loaded into a free output slot.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!out_valid_reg || out_ready))
        else $error("output beat overwritten");

    // The CRC restarts after the final beat of a section.
    a_crc_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && cmd.last) |=> (crc_reg == CRC_INIT) && (mod_reg == '0))
        else $error("CRC not restarted after section end");

    // The byte position never reaches the largest datagram length.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < LEN_W'(MAX_DATAGRAM))
        else $error("byte position out of range");

    // A stuffing run is never empty and always closes the section.
    a_run_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && is_stuff_run_reg) |-> (run_length_reg != 8'h00) && last_reg)
        else $error("malformed stuffing run");

endmodule

`default_nettype wire

// File: rtl/core/mpe_section_encapsulator_core.sv
`default_nettype none

// Channel   Handshake               Payload
// -------   ---------------------   ------------------------------------------
// config    cfg_write_en            cfg_write_data (stuffing enable)
// input     in_valid / in_ready     data_byte, datagram_length
// output    out_valid / out_ready   out_byte, is_stuff_run, run_length, last
//
// Datagram bytes from the 21st on are taken at one per cycle while the output slot is
// free and pass straight through the output register. The first 20 bytes are stored at
// one per cycle; the header burst then sends the 12 header bytes and the n held bytes
// (up to 20), the closing burst the 4 CRC bytes, plus a stuffing run when one is needed;
// the input waits during bursts, which the controller sequences through the single
// output register. Reset needs no clearing pass; output stalls hold the burst in place.

module mpe_section_encapsulator_core
    import mpe_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write_en,
    input  wire logic             cfg_write_data,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [7:0]       data_byte,
    input  wire logic [LEN_W-1:0] datagram_length,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [7:0]            out_byte,
    output logic                  is_stuff_run,
    output logic [7:0]            run_length,
    output logic                  last
);

    mpe_cmd_t    cmd;
    mpe_status_t st;

    // Sequencing of header, prefix, CRC and stuffing beats.
    mpe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // Prefix store, CRC, counters and output register.
    mpe_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .data_byte       (data_byte),
        .datagram_length (datagram_length),
        .cmd             (cmd),
        .st              (st),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .out_byte        (out_byte),
        .is_stuff_run    (is_stuff_run),
        .run_length      (run_length),
        .last            (last)
    );

endmodule

`default_nettype wire

// File: sim/mpe_section_encapsulator_core_test.sv
module mpe_section_encapsulator_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mpe_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_PRINTED   = 40;

    // One output beat of a section as the block should present it.
    typedef struct packed {
        logic [7:0] data_val;
        logic       stuff_run;
        logic [7:0] fill_len;
        logic       end_of_section;
    } section_beat_t;

    logic             clk             = 1'b0;
    logic             rst_n           = 1'b0;
    logic             cfg_write_en    = 1'b0;
    logic             cfg_write_data  = 1'b0;
    logic             in_valid        = 1'b0;
    logic             in_ready;
    logic [7:0]       data_byte       = 8'h00;
    logic [LEN_W-1:0] datagram_length = '0;
    logic             out_valid;
    logic             out_ready       = 1'b0;
    logic [7:0]       out_byte;
    logic             is_stuff_run;
    logic [7:0]       run_length;
    logic             last;

    // Shadow state of the encapsulator.
    logic [7:0]       held_prefix [PREFIX_LEN];
    int               dgram_pos   = 0;
    logic [31:0]      running_crc = CRC_INIT;
    logic             stuff_on    = 1'b0;
    section_beat_t    section_beats [$];

    // Traffic shaping and bookkeeping.
    int in_idle_pct   = 35;
    int out_idle_pct  = 35;
    int hold_off_left = 0;
    int cycle_count   = 0;
    int mismatch_count = 0;
    int bytes_accepted = 0;
    int beats_checked  = 0;
    int sections_closed = 0;
    int stuff_runs_seen = 0;
    int mcast_headers   = 0;
    int cfg_writes      = 0;

    mpe_section_encapsulator_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .datagram_length (datagram_length),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_byte        (out_byte),
        .is_stuff_run    (is_stuff_run),
        .run_length      (run_length),
        .last            (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // MPEG-2 CRC-32 over one byte, most significant bit first.
    function automatic logic [31:0] mpeg_crc_byte(logic [31:0] crc, logic [7:0] d);
        logic [31:0] c;
        c = crc ^ {d, 24'h000000};
        for (int k = 0; k < 8; k++)
        begin
            c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
        end
        return c;
    endfunction

    task automatic push_beat(input logic [7:0] v, input logic run, input logic [7:0] n,
                             input logic eos);
        section_beat_t b;
        b.data_val       = v;
        b.stuff_run      = run;
        b.fill_len       = n;
        b.end_of_section = eos;
        section_beats.push_back(b);
    endtask

    // A header or datagram beat also feeds the section CRC.
    task automatic push_covered(input logic [7:0] v);
        running_crc = mpeg_crc_byte(running_crc, v);
        push_beat(v, 1'b0, 8'h00, 1'b0);
    endtask

    // Works out the beats that one accepted datagram byte releases.
    task automatic encapsulate_byte(input logic [7:0] b, input logic [LEN_W-1:0] len_in);
        int               len;
        int               pos;
        int               total;
        int               fill;
        logic             ends;
        logic             add_run;
        logic [LEN_W-1:0] slen;
        logic [31:0]      crc_out;
        logic [7:0]       pre [PREFIX_LEN];
        logic [7:0]       hdr [HDR_LEN];
        len = (len_in == 0) ? 1 : int'(len_in);
        if (len > MAX_DATAGRAM)
            len = MAX_DATAGRAM;
        pos = dgram_pos;
        ends = (pos + 1 >= len) || (pos + 1 >= MAX_DATAGRAM);

        if (pos < PREFIX_LEN)
        begin
            held_prefix[pos] = b;
            // The header goes out once the prefix is complete or the datagram ends.
            if (pos == PREFIX_LEN - 1 || ends)
            begin
                for (int i = 0; i < PREFIX_LEN; i++)
                    pre[i] = (i <= pos) ? held_prefix[i] : 8'h00;
                for (int i = 0; i < HDR_LEN; i++)
                    hdr[i] = 8'h00;
                slen = LEN_W'(len + SLEN_EXTRA);
                hdr[0] = TABLE_ID;
                hdr[1] = SLEN_FLAGS | {4'h0, slen[11:8]};
                hdr[2] = slen[7:0];
                hdr[5] = HDR_FLAGS;
                // A multicast destination fills in the MAC address bytes.
                if ((pre[16] & MCAST_MASK) == MCAST_MASK)
                begin
                    hdr[3]  = pre[19];
                    hdr[4]  = pre[18];
                    hdr[8]  = pre[17] & MAC_LO_MASK;
                    hdr[9]  = MAC_OUI_MID;
                    hdr[11] = 8'h01;
                    mcast_headers++;
                end
                for (int i = 0; i < HDR_LEN; i++)
                    push_covered(hdr[i]);
                for (int i = 0; i <= pos; i++)
                    push_covered(pre[i]);
            end
        end
        else
        begin
            push_covered(b);
        end

        // Close the section with the CRC and, if enabled and the fill is not empty, one stuffing run.
        if (ends)
        begin
            crc_out = running_crc;
            total = HDR_LEN + pos + 1 + CRC_LEN;
            fill = (SECTION_MOD - 1) - (total % SECTION_MOD);
            add_run = stuff_on && (fill > 0);
            push_beat(crc_out[31:24], 1'b0, 8'h00, 1'b0);
            push_beat(crc_out[23:16], 1'b0, 8'h00, 1'b0);
            push_beat(crc_out[15:8], 1'b0, 8'h00, 1'b0);
            push_beat(crc_out[7:0], 1'b0, 8'h00, !add_run);
            if (add_run)
                push_beat(8'h00, 1'b1, 8'(fill), 1'b1);
            dgram_pos = 0;
            running_crc = CRC_INIT;
        end
        else
        begin
            dgram_pos = pos + 1;
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Compares one output beat with the oldest expected beat.
    task automatic check_beat();
        section_beat_t want;
        if (section_beats.size() == 0)
        begin
            report_mismatch($sformatf("beat with nothing expected: byte %02h run %0b len %0d last %0b",
                                      out_byte, is_stuff_run, run_length, last));
            return;
        end
        want = section_beats.pop_front();
        if (out_byte !== want.data_val || is_stuff_run !== want.stuff_run ||
            run_length !== want.fill_len || last !== want.end_of_section)
        begin
            report_mismatch($sformatf("beat %0d: got %02h/%0b/%0d/%0b want %02h/%0b/%0d/%0b",
                                      beats_checked, out_byte, is_stuff_run, run_length, last,
                                      want.data_val, want.stuff_run, want.fill_len,
                                      want.end_of_section));
        end
        beats_checked++;
        if (want.end_of_section)
            sections_closed++;
        if (want.stuff_run)
            stuff_runs_seen++;
    endtask

    // Input acceptance feeds the predictor first, so a same-edge result still finds it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                encapsulate_byte(data_byte, datagram_length);
                bytes_accepted++;
            end
            if (out_valid && out_ready)
                check_beat();
        end
    end

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_off_left > 0)
        begin
            out_ready <= 1'b0;
            hold_off_left--;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d beats outstanding",
                     cycle_count, section_beats.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offers one datagram byte and returns at the edge that accepts it.
    task automatic send_byte(input logic [7:0] b, input logic [LEN_W-1:0] len);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        data_byte       <= b;
        datagram_length <= len;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stops offering input until every expected beat has come out.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (section_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_stuffing(input logic enable);
        wait_for_drain();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= enable;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        stuff_on = enable;
        cfg_writes++;
    endtask

    // Sends a well-formed datagram of random content, optionally pausing partway.
    task automatic send_datagram(input int n, input bit mcast, input int pause_at);
        logic [7:0] b;
        for (int i = 0; i < n; i++)
        begin
            if (i == pause_at)
                wait_for_drain();
            b = 8'($urandom);
            if (i == 16 && mcast)
                b[7:5] = 3'b111;
            send_byte(b, LEN_W'(n));
        end
    endtask

    // Length zero, length one, with and without stuffing.
    task automatic test_single_byte_datagrams();
        set_stuffing(1'b0);
        send_byte(8'h00, LEN_W'(0));
        send_byte(8'hFF, LEN_W'(1));
        set_stuffing(1'b1);
        send_byte(8'hA5, LEN_W'(1));
        wait_for_drain();
    endtask

    // Multicast header under an oversized length that drops to zero on the closing byte.
    task automatic test_multicast_clamped_header();
        logic [7:0] b;
        for (int i = 0; i < PREFIX_LEN; i++)
        begin
            case (i)
                16:      b = 8'hE0;
                17:      b = 8'hFF;
                18:      b = 8'h5A;
                19:      b = 8'hC3;
                default: b = 8'($urandom);
            endcase
            send_byte(b, {LEN_W{1'b1}});
        end
        send_byte(8'h00, LEN_W'(0));
        wait_for_drain();
    endtask

    // A section that already ends one short of a 184 multiple needs no stuffing run.
    task automatic test_zero_fill();
        set_stuffing(1'b1);
        send_datagram(167, 1'b1, -1);
        wait_for_drain();
    endtask

    // Both sides run without idling.
    task automatic test_full_rate();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        send_datagram(5, 1'b0, -1);
        send_datagram(22, 1'b1, -1);
        wait_for_drain();
        in_idle_pct  = 35;
        out_idle_pct = 35;
    endtask

    // A long receiver stall while input keeps coming, so the input side backs up.
    task automatic test_output_backpressure();
        hold_off_left = 300;
        send_datagram(24, 1'b0, -1);
        wait_for_drain();
    endtask

    // Mostly well-formed datagrams, with some runs of erratic lengths.
    task automatic test_random_traffic(input int budget);
        int sent;
        int n;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(21, 40) : $urandom_range(1, 24);
                send_datagram(n, $urandom_range(0, 1),
                              ($urandom_range(0, 7) == 0) ? $urandom_range(0, n - 1) : -1);
                sent += n;
            end
            else
            begin
                // Lengths that change from byte to byte; a length of one closes the datagram.
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                begin
                    send_byte(8'($urandom), ($urandom_range(0, 3) == 0) ?
                              LEN_W'($urandom) : LEN_W'($urandom_range(2, 40)));
                end
                send_byte(8'($urandom), LEN_W'(1));
                sent += n + 1;
            end
            if ($urandom_range(0, 5) == 0)
                set_stuffing(!stuff_on);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_byte_datagrams();
        test_multicast_clamped_header();
        test_zero_fill();
        test_full_rate();
        test_output_backpressure();
        set_stuffing(1'b0);
        test_random_traffic(10);
        set_stuffing(1'b1);
        test_random_traffic(10);
        wait_for_drain();

        $display("Covered %0d datagram bytes in %0d sections: %0d beats, %0d multicast headers,",
                 bytes_accepted, sections_closed, beats_checked, mcast_headers);
        $display("%0d stuffing runs, %0d stuffing register writes, %0d mismatches.",
                 stuff_runs_seen, cfg_writes, mismatch_count);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
